### design/clbp_pkg.sv
// Package for the circular LBP operator (radius 2, 8 sampling points).
// Holds sizes, payload structs, tap tables and fixed-point weights.
// No dependencies.
package clbp_pkg;

  // Sizes
  localparam int MAX_WIDTH        = 1024;
  localparam int COL_W            = $clog2(MAX_WIDTH);
  localparam int FRAME_W_BITS     = 11;
  localparam int FRAME_H_BITS     = 12;
  localparam int CNT_W            = ((COL_W + 1) > FRAME_W_BITS) ? (COL_W + 1) : FRAME_W_BITS;
  localparam int MIN_SIZE         = 5;
  localparam int RESET_WIDTH      = 640;
  localparam int RESET_HEIGHT     = 480;

  // Row store: one word per column, four buffered rows side by side
  localparam int BUF_ROWS         = 4;
  localparam int RAM_W            = 8 * BUF_ROWS;

  // Configuration port
  localparam int CFG_DATA_W       = 12;
  localparam int CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Result queue
  localparam int FIFO_DEPTH       = 8;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
  localparam int LVL_W            = FIFO_PTR_W + 1;
  localparam int CREDIT_W         = LVL_W + 1;

  // Fixed-point weights
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int SUM_W            = 8 + WEIGHT_FRAC_BITS + 1;
  localparam longint unsigned Q32_AA = 64'd736899888;
  localparam longint unsigned Q32_AB = 64'd1042133816;
  localparam longint unsigned Q32_BB = 64'd1473799776;
  localparam longint unsigned RND    = 64'd1 << (31 - WEIGHT_FRAC_BITS);
  localparam longint unsigned W_AA   = (Q32_AA + RND) >> (32 - WEIGHT_FRAC_BITS);
  localparam longint unsigned W_AB   = (Q32_AB + RND) >> (32 - WEIGHT_FRAC_BITS);
  localparam longint unsigned W_BB   = (Q32_BB + RND) >> (32 - WEIGHT_FRAC_BITS);
  localparam longint unsigned W_ONE  = 64'd1 << WEIGHT_FRAC_BITS;

  // Weight classes
  localparam int CLS_ONE = 0;
  localparam int CLS_AA  = 1;
  localparam int CLS_AB  = 2;
  localparam int CLS_BB  = 3;

  localparam int NPTS     = 8;
  localparam int MAX_TAPS = 4;
  localparam int WIN      = 5;

  localparam int TAP_CNT [NPTS] = '{1, 4, 1, 4, 1, 4, 1, 4};
  localparam int TAP_DY [NPTS][MAX_TAPS] = '{
    '{ 0,  0,  0,  0},
    '{-2, -2, -1, -1},
    '{-2,  0,  0,  0},
    '{-2, -2, -1, -1},
    '{ 0,  0,  0,  0},
    '{ 1,  1,  2,  2},
    '{ 2,  0,  0,  0},
    '{ 1,  1,  2,  2}
  };
  localparam int TAP_DX [NPTS][MAX_TAPS] = '{
    '{ 2,  0,  0,  0},
    '{ 1,  2,  1,  2},
    '{ 0,  0,  0,  0},
    '{-2, -1, -2, -1},
    '{-2,  0,  0,  0},
    '{-2, -1, -2, -1},
    '{ 0,  0,  0,  0},
    '{ 1,  2,  1,  2}
  };
  localparam int TAP_CLS [NPTS][MAX_TAPS] = '{
    '{CLS_ONE, CLS_ONE, CLS_ONE, CLS_ONE},
    '{CLS_AB,  CLS_AA,  CLS_BB,  CLS_AB },
    '{CLS_ONE, CLS_ONE, CLS_ONE, CLS_ONE},
    '{CLS_AA,  CLS_AB,  CLS_AB,  CLS_BB },
    '{CLS_ONE, CLS_ONE, CLS_ONE, CLS_ONE},
    '{CLS_AB,  CLS_BB,  CLS_AA,  CLS_AB },
    '{CLS_ONE, CLS_ONE, CLS_ONE, CLS_ONE},
    '{CLS_BB,  CLS_AB,  CLS_AB,  CLS_AA }
  };

  function automatic logic [SUM_W-1:0] weight_of(input int cls);
    logic [SUM_W-1:0] w;
    case (cls)
      CLS_AA:  w = SUM_W'(W_AA);
      CLS_AB:  w = SUM_W'(W_AB);
      CLS_BB:  w = SUM_W'(W_BB);
      default: w = SUM_W'(W_ONE);
    endcase
    return w;
  endfunction

  // Payloads
  typedef struct packed {
    logic [7:0] pixel;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lbp_code;
    logic       end_of_frame;
  } out_item_t;

endpackage

### design/clbp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module clbp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/clbp_fifo.sv
// Result queue for the circular LBP operator, register based.
// Depends on clbp_pkg.
module clbp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  clbp_pkg::out_item_t          push_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output clbp_pkg::out_item_t          out_data,
  output logic [clbp_pkg::LVL_W-1:0]   level
);

  clbp_pkg::out_item_t mem [clbp_pkg::FIFO_DEPTH];
  logic [clbp_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [clbp_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic pop;

  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### design/circular_lbp_operator.sv
// Top level of the circular LBP operator (radius 2, 8 points, Q12 weights).
// Depends on clbp_pkg, clbp_ram, clbp_fifo.
//
//  channel  | signals                         | role
//  ---------+---------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data     | raster pixels, start_of_frame
//  out      | out_valid, out_ready, out_data  | lbp_code, end_of_frame
//  cfg      | cfg_we, cfg_index, cfg_wdata    | frame_width (0), frame_height (1)
//
// One pixel transfer per cycle while in_ready is high; a result passes through the row RAM
// read, window shift, weighted sums, and compare and queue push before out_valid rises.
// Row RAM: one 32-bit word per column (four rows), read, then written back next
// cycle; a read of the column written that cycle takes the forwarded word.
// rst (synchronous) clears counters, window, pipeline and queue, not the row RAM.
// 8-entry result queue; in_ready drops once queued plus in-flight items reach 8.
module circular_lbp_operator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  clbp_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output clbp_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [clbp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CW = clbp_pkg::CNT_W;
  localparam int HW = clbp_pkg::FRAME_H_BITS;

  // Configuration registers
  logic [clbp_pkg::FRAME_W_BITS-1:0] frame_width;
  logic [HW-1:0]                     frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= clbp_pkg::FRAME_W_BITS'(clbp_pkg::RESET_WIDTH);
      frame_height <= HW'(clbp_pkg::RESET_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        clbp_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_wdata[clbp_pkg::FRAME_W_BITS-1:0];
        clbp_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_wdata[HW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [5, MAX_WIDTH], height at least 5
  logic [CW-1:0] w_eff;
  logic [CW-1:0] fw_ext;
  logic [HW-1:0] h_eff;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext < CW'(clbp_pkg::MIN_SIZE)) begin
      w_eff = CW'(clbp_pkg::MIN_SIZE);
    end else if (fw_ext > CW'(clbp_pkg::MAX_WIDTH)) begin
      w_eff = CW'(clbp_pkg::MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (frame_height < HW'(clbp_pkg::MIN_SIZE)) ? HW'(clbp_pkg::MIN_SIZE) : frame_height;
  end

  // ---------------------------------------------------------------------
  // Stage 0: input transfer, raster counters, RAM read issue
  // ---------------------------------------------------------------------
  logic [clbp_pkg::COL_W-1:0] col_cnt;
  logic [HW-1:0]              row_cnt;
  logic [clbp_pkg::COL_W-1:0] col_cur;
  logic [HW-1:0]              row_cur;
  logic [clbp_pkg::COL_W-1:0] col_next;
  logic [HW-1:0]              row_next;
  logic [CW-1:0]              col_inc;
  logic [HW:0]                row_inc;
  logic                       col_wrap;
  logic                       emit0;
  logic                       eof0;
  logic                       acc;

  logic v1, v2, v3;
  logic [clbp_pkg::LVL_W-1:0]    q_level;
  logic [clbp_pkg::CREDIT_W-1:0] credit_used;

  // Every in-flight item reserves a queue slot, so the pipeline never stalls.
  assign credit_used = clbp_pkg::CREDIT_W'(q_level) + clbp_pkg::CREDIT_W'(v1)
                     + clbp_pkg::CREDIT_W'(v2) + clbp_pkg::CREDIT_W'(v3);
  assign in_ready    = credit_used < clbp_pkg::CREDIT_W'(clbp_pkg::FIFO_DEPTH);
  assign acc         = in_valid && in_ready;

  always_comb begin
    col_cur  = in_data.start_of_frame ? '0 : col_cnt;
    row_cur  = in_data.start_of_frame ? '0 : row_cnt;
    emit0    = (row_cur >= HW'(4)) && (col_cur >= clbp_pkg::COL_W'(4))
             && (row_cur < h_eff) && (CW'(col_cur) < w_eff);
    eof0     = (row_cur == h_eff - 1'b1) && (CW'(col_cur) == w_eff - 1'b1);
    col_inc  = CW'(col_cur) + 1'b1;
    col_wrap = col_inc >= w_eff;
    row_inc  = {1'b0, row_cur} + 1'b1;
    col_next = col_wrap ? '0 : col_inc[clbp_pkg::COL_W-1:0];
    if (!col_wrap) begin
      row_next = row_cur;
    end else if (row_inc >= {1'b0, h_eff}) begin
      row_next = '0;
    end else begin
      row_next = row_inc[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
    end
  end

  // Stage 1 registers: RAM read in flight
  logic [7:0]                 px1;
  logic [1:0]                 slot1;
  logic [clbp_pkg::COL_W-1:0] addr1;
  logic                       emit1, eof1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1   <= in_data.pixel;
      slot1 <= row_cur[1:0];
      addr1 <= col_cur;
      emit1 <= emit0;
      eof1  <= eof0;
    end
  end

  // Row RAM: byte s of a word holds the row whose index mod 4 is s.
  logic [clbp_pkg::RAM_W-1:0] ram_rdata;
  logic [clbp_pkg::RAM_W-1:0] ram_wdata;
  logic [clbp_pkg::RAM_W-1:0] rd_word;
  logic [clbp_pkg::RAM_W-1:0] fwd_word;
  logic                       fwd_hit;

  // A start_of_frame can bring back the column written in the same cycle;
  // that read returns the old word, so the written word is forwarded.
  clbp_ram #(
    .DATA_W (clbp_pkg::RAM_W),
    .DEPTH  (clbp_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (v1),
    .waddr (addr1),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= acc && v1 && (col_cur == addr1);
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      fwd_word <= ram_wdata;
    end
  end

  assign rd_word = fwd_hit ? fwd_word : ram_rdata;

  // ---------------------------------------------------------------------
  // Stage 1: column unpack, row write-back, window shift
  // ---------------------------------------------------------------------
  logic [7:0] col_px [clbp_pkg::WIN];
  logic [1:0] rd_slot [clbp_pkg::BUF_ROWS];

  always_comb begin
    // col_px[0] is the oldest row (r-4), col_px[4] the incoming pixel
    for (int k = 0; k < clbp_pkg::BUF_ROWS; k++) begin
      rd_slot[k] = slot1 + 2'(k);
      col_px[k]  = rd_word[8*rd_slot[k] +: 8];
    end
    col_px[clbp_pkg::BUF_ROWS] = px1;
    ram_wdata = rd_word;
    ram_wdata[8*slot1 +: 8] = px1;
  end

  logic [7:0] win [clbp_pkg::WIN][clbp_pkg::WIN];
  logic       emit2, eof2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < clbp_pkg::WIN; i++) begin
        for (int j = 0; j < clbp_pkg::WIN; j++) begin
          win[i][j] <= '0;
        end
      end
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
      if (v1) begin
        for (int i = 0; i < clbp_pkg::WIN; i++) begin
          for (int j = 0; j < clbp_pkg::WIN - 1; j++) begin
            win[i][j] <= win[i][j+1];
          end
          win[i][clbp_pkg::WIN-1] <= col_px[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      emit2 <= emit1;
      eof2  <= eof1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: weighted sums of the eight sampling points
  // ---------------------------------------------------------------------
  logic [clbp_pkg::SUM_W-1:0] sum_c  [clbp_pkg::NPTS];
  logic [clbp_pkg::SUM_W-1:0] sum3   [clbp_pkg::NPTS];
  logic [7:0]                 center3;
  logic                       emit3, eof3;

  always_comb begin
    for (int n = 0; n < clbp_pkg::NPTS; n++) begin
      sum_c[n] = '0;
      for (int k = 0; k < clbp_pkg::MAX_TAPS; k++) begin
        if (k < clbp_pkg::TAP_CNT[n]) begin
          sum_c[n] = sum_c[n]
            + clbp_pkg::weight_of(clbp_pkg::TAP_CLS[n][k])
            * clbp_pkg::SUM_W'(win[2 + clbp_pkg::TAP_DY[n][k]][2 + clbp_pkg::TAP_DX[n][k]]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      for (int n = 0; n < clbp_pkg::NPTS; n++) begin
        sum3[n] <= sum_c[n];
      end
      center3 <= win[2][2];
      emit3   <= emit2;
      eof3    <= eof2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: compare against the scaled center, push into the queue
  // ---------------------------------------------------------------------
  logic [clbp_pkg::SUM_W-1:0] center_q;
  clbp_pkg::out_item_t        res;

  always_comb begin
    center_q = clbp_pkg::SUM_W'(center3) << clbp_pkg::WEIGHT_FRAC_BITS;
    for (int n = 0; n < clbp_pkg::NPTS; n++) begin
      res.lbp_code[n] = sum3[n] >= center_q;
    end
    res.end_of_frame = eof3;
  end

  clbp_fifo u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (v3 && emit3),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (q_level)
  );

endmodule

### design/clbp_checker.sv
// Port-level checks for circular_lbp_operator, attached by bind.
// Depends on clbp_pkg.
module clbp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input clbp_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input clbp_pkg::out_item_t             out_data
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting pixel holds until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("pixel changed while stalled");

  // Nothing is left to show right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // An empty queue fills only from a pixel taken earlier, through the pipeline stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result without matching pixel transfer");

  // Input backpressure only while results wait downstream.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind circular_lbp_operator clbp_checker u_clbp_checker (.*);
